// File: src/mms_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the pointer motion smoother.
// Used by mms_divider and mouse_motion_smoother; depends on nothing.
package mms_pkg;

   localparam int HIST_DEPTH = 10;
   localparam int IDX_W      = $clog2(HIST_DEPTH);
   localparam int POS_W      = 16;
   localparam int MOV_W      = POS_W + 1;
   localparam int WT_W       = 17;
   localparam int SMOOTH_W   = 16;
   localparam int WT_FRAC    = 16;
   localparam int SUMW_W     = WT_W + $clog2(HIST_DEPTH);
   localparam int ACC_W      = MOV_W + SUMW_W;
   localparam int MAG_W      = ACC_W - 1;
   localparam int OUT_FRAC   = 8;
   localparam int NUM_W      = MAG_W + OUT_FRAC + 2;
   localparam int DEN2_W     = SUMW_W + 1;
   localparam int QUO_W      = 25;
   localparam int QCNT_W     = $clog2(QUO_W + 1);
   localparam int MUL_W      = WT_W + 1;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 72;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [WT_W-1:0]     WT_ONE       = WT_W'(65536);
   localparam logic [SMOOTH_W-1:0] SMOOTH_RESET = SMOOTH_W'(32768);
   localparam logic [QUO_W-1:0]    MOVE_LIMIT   = QUO_W'(16776960);

   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTHING = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_VISIBLE   = 1'b1;

   typedef enum logic [1:0] {
      OP_MX = 2'b00,
      OP_MY = 2'b01,
      OP_WT = 2'b10
   } op_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// File: src/mms_divider.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, with round-to-nearest numerator.
// Depends on mms_pkg.
module mms_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [mms_pkg::MAG_W-1:0]        num_mag,
   input  logic [mms_pkg::SUMW_W-1:0]       den,
   output mms_pkg::div_stat_type            stat,
   output logic [mms_pkg::QUO_W-1:0]        quo
);

   logic [mms_pkg::NUM_W-1:0]  numer;
   logic [mms_pkg::DEN2_W-1:0] rem_ff;
   logic [mms_pkg::DEN2_W-1:0] dsr_ff;
   logic [mms_pkg::QUO_W-1:0]  low_ff;
   logic [mms_pkg::QCNT_W-1:0] cnt_ff;
   logic                       busy_ff;
   logic                       done_ff;
   logic [mms_pkg::DEN2_W:0]   trial;
   logic [mms_pkg::DEN2_W:0]   diff;

   // 2 * mag * 256 + den
   assign numer = {1'b0, num_mag, {(mms_pkg::OUT_FRAC + 1){1'b0}}}
                  + mms_pkg::NUM_W'(den);
   assign trial = {rem_ff, low_ff[mms_pkg::QUO_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= mms_pkg::QCNT_W'(mms_pkg::QUO_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == mms_pkg::QCNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= numer[mms_pkg::NUM_W-1:mms_pkg::QUO_W];
         low_ff <= numer[mms_pkg::QUO_W-1:0];
         dsr_ff <= {den, 1'b0};
      end else if (busy_ff) begin
         if (!diff[mms_pkg::DEN2_W]) begin
            rem_ff <= diff[mms_pkg::DEN2_W-1:0];
            low_ff <= {low_ff[mms_pkg::QUO_W-2:0], 1'b1};
         end else begin
            rem_ff <= trial[mms_pkg::DEN2_W-1:0];
            low_ff <= {low_ff[mms_pkg::QUO_W-2:0], 1'b0};
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quo       = low_ff;

endmodule

// File: src/mouse_motion_smoother.sv
`timescale 1ns / 1ps
// Pointer motion smoother: geometric weighted average over a ring of movements.
// Each tick is a multiply-accumulate pass over the history on one shared 18x18
// multiplier, then an x and a y quotient on the bit-serial divider, then a registered
// result beat; no new tick is taken until the last one's beat is registered, and a held result stalls.
// Synchronous reset clears history, button levels, reference point and config.
// Depends on mms_pkg and mms_divider.
module mouse_motion_smoother (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // pos_x[15:0], pos_y[31:16], left_down[32], right_down[33], wheel_in[49:34]
   input  logic [mms_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // move_x[24:0], move_y[49:25], left_press[50], left_release[51],
   // right_press[52], right_release[53], wheel_out[69:54]
   output logic [mms_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                csr_we,
   input  logic [mms_pkg::CSR_IDX_W-1:0]       csr_addr,
   input  logic [mms_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_MUL  = 8'b0000_0010,
      ST_ACC  = 8'b0000_0100,
      ST_DXS  = 8'b0000_1000,
      ST_DXW  = 8'b0001_0000,
      ST_DYS  = 8'b0010_0000,
      ST_DYW  = 8'b0100_0000,
      ST_DONE = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   mms_pkg::op_type op_ff, op_in;

   logic [mms_pkg::SMOOTH_W-1:0]   smoothing_ff;
   logic                           visible_ff;
   logic                           clear_hist;
   logic signed [mms_pkg::MOV_W-1:0] hist_x_ff [mms_pkg::HIST_DEPTH];
   logic signed [mms_pkg::MOV_W-1:0] hist_y_ff [mms_pkg::HIST_DEPTH];
   logic [mms_pkg::IDX_W-1:0]      newest_ff, newest_in;
   logic                           first_ff;
   logic [mms_pkg::POS_W-1:0]      ref_x_ff, ref_y_ff;
   logic                           last_left_ff, last_right_ff;

   logic [mms_pkg::IDX_W-1:0]      slot_ff, slot_in;
   logic [mms_pkg::IDX_W-1:0]      tap_ff, tap_in;
   logic [mms_pkg::WT_W-1:0]       w_ff, w_in;
   logic [mms_pkg::SUMW_W-1:0]     sum_w_ff, sum_w_in;
   logic signed [mms_pkg::ACC_W-1:0] acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;
   logic signed [mms_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [mms_pkg::MUL_W-1:0]  mul_a, mul_b;

   logic [3:0]                     edge_ff;
   logic [mms_pkg::POS_W-1:0]      wheel_ff;
   logic [mms_pkg::QUO_W-1:0]      move_x_ff;
   logic [mms_pkg::QUO_W-1:0]      move_y_ff;
   logic                           rsp_tvalid_ff, rsp_tvalid_in;
   logic [mms_pkg::RSP_DATA_W-1:0] rsp_tdata_ff;

   logic                           accept;
   logic [mms_pkg::POS_W-1:0]      in_px, in_py, in_wheel;
   logic                           in_left, in_right;
   logic signed [mms_pkg::MOV_W-1:0] mov_x, mov_y;

   logic                           div_start;
   logic [mms_pkg::MAG_W-1:0]      div_num;
   logic [mms_pkg::ACC_W-1:0]      abs_val;
   logic                           div_neg;
   mms_pkg::div_stat_type          div_stat;
   logic [mms_pkg::QUO_W-1:0]      div_quo;
   logic [mms_pkg::QUO_W-1:0]      q_sat, move_val;

   assign in_px    = req_tdata[15:0];
   assign in_py    = req_tdata[31:16];
   assign in_left  = req_tdata[32];
   assign in_right = req_tdata[33];
   assign in_wheel = req_tdata[49:34];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign clear_hist = csr_we && (csr_addr == mms_pkg::CSR_VISIBLE) && csr_wdata[0];

   always_comb begin
      mov_x = {in_px[15], in_px} - {ref_x_ff[15], ref_x_ff};
      mov_y = {in_py[15], in_py} - {ref_y_ff[15], ref_y_ff};
      if (visible_ff && !in_right) begin
         mov_x = '0;
         mov_y = '0;
      end
      if (newest_ff == mms_pkg::IDX_W'(mms_pkg::HIST_DEPTH - 1)) begin
         newest_in = '0;
      end else begin
         newest_in = newest_ff + 1'b1;
      end
   end

   // shared multiplier operand select
   always_comb begin
      mul_b = {1'b0, w_ff};
      case (op_ff)
         mms_pkg::OP_MX: mul_a = {hist_x_ff[slot_ff][mms_pkg::MOV_W-1], hist_x_ff[slot_ff]};
         mms_pkg::OP_MY: mul_a = {hist_y_ff[slot_ff][mms_pkg::MOV_W-1], hist_y_ff[slot_ff]};
         mms_pkg::OP_WT: mul_a = {2'b00, smoothing_ff};
         default:        mul_a = '0;
      endcase
      prod_in = mul_a * mul_b;
   end

   always_comb begin
      div_neg   = (state_ff == ST_DYS || state_ff == ST_DYW) ? acc_y_ff[mms_pkg::ACC_W-1]
                                                             : acc_x_ff[mms_pkg::ACC_W-1];
      abs_val   = (state_ff == ST_DYS) ?
                  (acc_y_ff[mms_pkg::ACC_W-1] ? -acc_y_ff : acc_y_ff) :
                  (acc_x_ff[mms_pkg::ACC_W-1] ? -acc_x_ff : acc_x_ff);
      div_num   = abs_val[mms_pkg::MAG_W-1:0];
      div_start = (state_ff == ST_DXS) || (state_ff == ST_DYS);
      q_sat     = (div_quo > mms_pkg::MOVE_LIMIT) ? mms_pkg::MOVE_LIMIT : div_quo;
      move_val  = div_neg ? -q_sat : q_sat;
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      slot_in       = slot_ff;
      tap_in        = tap_ff;
      w_in          = w_ff;
      sum_w_in      = sum_w_ff;
      acc_x_in      = acc_x_ff;
      acc_y_in      = acc_y_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_MUL;
               op_in    = mms_pkg::OP_MX;
               slot_in  = first_ff ? newest_ff : newest_in;
               tap_in   = '0;
               w_in     = mms_pkg::WT_ONE;
               sum_w_in = '0;
               acc_x_in = '0;
               acc_y_in = '0;
            end
         end
         ST_MUL: state_in = ST_ACC;
         ST_ACC: begin
            state_in = ST_MUL;
            case (op_ff)
               mms_pkg::OP_MX: begin
                  acc_x_in = acc_x_ff + mms_pkg::ACC_W'(prod_ff);
                  op_in    = mms_pkg::OP_MY;
               end
               mms_pkg::OP_MY: begin
                  acc_y_in = acc_y_ff + mms_pkg::ACC_W'(prod_ff);
                  op_in    = mms_pkg::OP_WT;
               end
               default: begin
                  sum_w_in = sum_w_ff + mms_pkg::SUMW_W'(w_ff);
                  w_in     = prod_ff[mms_pkg::WT_FRAC+mms_pkg::WT_W-1:mms_pkg::WT_FRAC];
                  op_in    = mms_pkg::OP_MX;
                  tap_in   = tap_ff + 1'b1;
                  slot_in  = (slot_ff == '0) ? mms_pkg::IDX_W'(mms_pkg::HIST_DEPTH - 1)
                                             : slot_ff - 1'b1;
                  if (tap_ff == mms_pkg::IDX_W'(mms_pkg::HIST_DEPTH - 1)) begin
                     state_in = ST_DXS;
                  end
               end
            endcase
         end
         ST_DXS: state_in = ST_DXW;
         ST_DXW: if (div_stat.done) state_in = ST_DYS;
         ST_DYS: state_in = ST_DYW;
         ST_DYW: if (div_stat.done) state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         op_ff         <= mms_pkg::OP_MX;
         smoothing_ff  <= mms_pkg::SMOOTH_RESET;
         visible_ff    <= 1'b1;
         newest_ff     <= '0;
         first_ff      <= 1'b1;
         ref_x_ff      <= '0;
         ref_y_ff      <= '0;
         last_left_ff  <= 1'b0;
         last_right_ff <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         w_ff          <= mms_pkg::WT_ONE;
         sum_w_ff      <= '0;
         tap_ff        <= '0;
         slot_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         op_ff         <= op_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         w_ff          <= w_in;
         sum_w_ff      <= sum_w_in;
         tap_ff        <= tap_in;
         slot_ff       <= slot_in;
         if (csr_we) begin
            unique case (csr_addr)
               mms_pkg::CSR_SMOOTHING: smoothing_ff <= csr_wdata;
               mms_pkg::CSR_VISIBLE:   visible_ff   <= csr_wdata[0];
               default: ;
            endcase
         end
         if (accept) begin
            first_ff      <= 1'b0;
            last_left_ff  <= in_left;
            last_right_ff <= in_right;
            if (!first_ff) newest_ff <= newest_in;
            if (visible_ff) begin
               ref_x_ff <= in_px;
               ref_y_ff <= in_py;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear_hist) begin
         for (int i = 0; i < mms_pkg::HIST_DEPTH; i++) begin
            hist_x_ff[i] <= '0;
            hist_y_ff[i] <= '0;
         end
      end else if (accept && !first_ff) begin
         hist_x_ff[newest_in] <= mov_x;
         hist_y_ff[newest_in] <= mov_y;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      acc_x_ff <= acc_x_in;
      acc_y_ff <= acc_y_in;
      if (accept) begin
         edge_ff  <= {!in_right && last_right_ff, in_right && !last_right_ff,
                      !in_left && last_left_ff, in_left && !last_left_ff};
         wheel_ff <= in_wheel;
      end
      if (state_ff == ST_DXW && div_stat.done) begin
         move_x_ff <= move_val;
      end
      if (state_ff == ST_DYW && div_stat.done) begin
         move_y_ff <= move_val;
      end
      if (state_ff == ST_DONE && (!rsp_tvalid_ff || rsp_tready)) begin
         rsp_tdata_ff <= {2'b00, wheel_ff, edge_ff, move_y_ff, move_x_ff};
      end
   end

   mms_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .num_mag (div_num),
      .den     (sum_w_ff),
      .stat    (div_stat),
      .quo     (div_quo)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("block ready straight after an accepted beat");

   a_weight_bound: assert property (@(posedge clock) disable iff (reset)
      w_ff <= mms_pkg::WT_ONE)
      else $error("weight above one");

   a_den_floor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DXS) |-> (sum_w_ff >= mms_pkg::SUMW_W'(mms_pkg::WT_ONE)))
      else $error("weight sum below one at divide");

   a_div_done_place: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_DXW || state_ff == ST_DYW))
      else $error("divider finished outside a wait state");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider started while busy");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result beat changed while waiting");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench of mouse_motion_smoother: a directed table followed by randomised pointer ticks.
// Predicts motion beats in SystemVerilog, takes known rows' typed results, checks the rsp_ stream in order.
// Depends on mms_pkg and mouse_motion_smoother.
module tb_top;
   import mms_pkg::*;

   localparam int CLOCK_HALF   = 5;
   localparam int CYCLE_LIMIT  = 500_000;
   localparam int HOLD_CYCLES  = 700;
   localparam int DRAIN_CYCLES = 130;
   localparam int PHASES       = 10;
   localparam int PHASE_TICKS  = 54;
   localparam int REPORT_MAX   = 10;
   localparam int TABLE_ROWS   = 22;

   typedef struct packed {
      logic [15:0] wheel;
      logic        right;
      logic        left;
      logic [15:0] py;
      logic [15:0] px;
   } tick_type;

   typedef struct packed {
      logic [15:0]      wheel;
      logic             right_release;
      logic             right_press;
      logic             left_release;
      logic             left_press;
      logic [QUO_W-1:0] my;
      logic [QUO_W-1:0] mx;
   } motion_type;

   typedef enum {ROW_CFG, ROW_TICK, ROW_KNOWN} row_kind_type;

   typedef struct {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] addr;
      int                   value;
      int                   px;
      int                   py;
      bit                   left;
      bit                   right;
      int                   wheel;
      int                   kmx;
      int                   kmy;
      bit                   klp;
      bit                   klr;
      bit                   krp;
      bit                   krr;
   } row_type;

   // kind, addr, value, px, py, left, right, wheel, then the typed result where known
   row_type dir_rows [TABLE_ROWS] = '{
      '{ROW_CFG,   CSR_VISIBLE,   0,      0,      0, 1'b0, 1'b0,      0,
        0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_KNOWN, CSR_SMOOTHING, 0,    100,    200, 1'b1, 1'b0,  32767,
        0, 0, 1'b1, 1'b0, 1'b0, 1'b0},
      '{ROW_TICK,  CSR_SMOOTHING, 0, -32768,  32767, 1'b0, 1'b1, -32768,
        0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_TICK,  CSR_SMOOTHING, 0,  32767, -32768, 1'b1, 1'b1,      1,
        0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_TICK,  CSR_SMOOTHING, 0,      0,      0, 1'b0, 1'b0,     -1,
        0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_CFG,   CSR_VISIBLE,   1,      0,      0, 1'b0, 1'b0,      0,
        0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_KNOWN, CSR_SMOOTHING, 0,      5,     -7, 1'b0, 1'b0,      0,
        0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_TICK,  CSR_SMOOTHING, 0,   1000,  -1000, 1'b1, 1'b1,    100,
        0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_TICK,  CSR_SMOOTHING, 0, -32768, -32768, 1'b0, 1'b0,   -100,
        0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_CFG,   CSR_SMOOTHING, 0,      0,      0, 1'b0, 1'b0,      0,
        0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_KNOWN, CSR_SMOOTHING, 0,  32767,  32767, 1'b0, 1'b1,  12345,
        16776960, 16776960, 1'b0, 1'b0, 1'b1, 1'b0},
      '{ROW_KNOWN, CSR_SMOOTHING, 0, -32768, -32768, 1'b1, 1'b1, -12345,
        -16776960, -16776960, 1'b1, 1'b0, 1'b0, 1'b0},
      '{ROW_CFG,   CSR_SMOOTHING, 65535,  0,      0, 1'b0, 1'b0,      0,
        0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_CFG,   CSR_VISIBLE,   0,      0,      0, 1'b0, 1'b0,      0,
        0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_TICK,  CSR_SMOOTHING, 0,  32767,  32767, 1'b1, 1'b0,      0,
        0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_TICK,  CSR_SMOOTHING, 0,  32767,  32767, 1'b0, 1'b0,      0,
        0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_TICK,  CSR_SMOOTHING, 0, -32768,  32767, 1'b0, 1'b1, -32768,
        0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_CFG,   CSR_SMOOTHING, 1,      0,      0, 1'b0, 1'b0,      0,
        0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_TICK,  CSR_SMOOTHING, 0,     -1,     -1, 1'b1, 1'b1,     -1,
        0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_CFG,   CSR_VISIBLE,   1,      0,      0, 1'b0, 1'b0,      0,
        0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_TICK,  CSR_SMOOTHING, 0,      0,     -1, 1'b0, 1'b0,  21845,
        0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_TICK,  CSR_SMOOTHING, 0, -21846,  21845, 1'b1, 1'b1, -21846,
        0, 0, 1'b0, 1'b0, 1'b0, 1'b0}
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // predicted state of the smoother
   int                  trail_x [HIST_DEPTH] = '{default: 0};
   int                  trail_y [HIST_DEPTH] = '{default: 0};
   int                  newest     = 0;
   bit                  fresh      = 1'b1;
   int                  anchor_x   = 0;
   int                  anchor_y   = 0;
   bit                  held_left  = 1'b0;
   bit                  held_right = 1'b0;
   logic [SMOOTH_W-1:0] smoothing  = SMOOTH_RESET;
   bit                  visible    = 1'b1;

   motion_type pending_motion [$];

   int     ticks_sent    = 0;
   int     beats_checked = 0;
   int     mismatches    = 0;
   int     strays        = 0;
   int     reg_writes    = 0;
   int     tx_idle_pct   = 35;
   int     rx_idle_pct   = 35;
   int     holds_asked   = 0;
   int     holds_served  = 0;
   longint cycle_count   = 0;
   int     cur_x         = 0;
   int     cur_y         = 0;
   bit     lvl_left      = 1'b0;
   bit     lvl_right     = 1'b0;
   motion_type seen;
   motion_type want;

   mouse_motion_smoother dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   function automatic longint rounded_quotient(longint num, longint den);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q = (2 * mag + den) / (2 * den);
      if (q > longint'(MOVE_LIMIT)) q = longint'(MOVE_LIMIT);
      return (num < 0) ? -q : q;
   endfunction

   function automatic motion_type smooth_tick(tick_type t);
      motion_type r;
      int      dx;
      int      dy;
      int      slot;
      longint  acc_x;
      longint  acc_y;
      longint  wsum;
      longint  wt;
      dx = int'($signed(t.px)) - anchor_x;
      dy = int'($signed(t.py)) - anchor_y;
      if (visible && !t.right) begin
         dx = 0;
         dy = 0;
      end
      if (fresh) begin
         fresh = 1'b0;
      end else begin
         newest = (newest + 1) % HIST_DEPTH;
         trail_x[newest] = dx;
         trail_y[newest] = dy;
      end
      if (visible) begin
         anchor_x = int'($signed(t.px));
         anchor_y = int'($signed(t.py));
      end
      acc_x = 0;
      acc_y = 0;
      wsum  = 0;
      wt    = longint'(WT_ONE);
      for (int i = 0; i < HIST_DEPTH; i++) begin
         slot  = (newest + HIST_DEPTH - i) % HIST_DEPTH;
         acc_x += longint'(trail_x[slot]) * wt;
         acc_y += longint'(trail_y[slot]) * wt;
         wsum  += wt;
         wt    = (wt * longint'(smoothing)) >>> WT_FRAC;
      end
      r.mx            = QUO_W'(rounded_quotient(acc_x * 256, wsum));
      r.my            = QUO_W'(rounded_quotient(acc_y * 256, wsum));
      r.left_press    = t.left && !held_left;
      r.left_release  = !t.left && held_left;
      r.right_press   = t.right && !held_right;
      r.right_release = !t.right && held_right;
      r.wheel         = t.wheel;
      held_left       = t.left;
      held_right      = t.right;
      return r;
   endfunction

   task automatic write_reg(logic [CSR_IDX_W-1:0] addr, int value);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= CSR_DATA_W'(value);
      @(negedge clock);
      csr_we <= 1'b0;
      if (addr == CSR_SMOOTHING) begin
         smoothing = SMOOTH_W'(value);
      end else begin
         visible = (value & 1) != 0;
         if (visible) begin
            trail_x = '{default: 0};
            trail_y = '{default: 0};
         end
      end
      reg_writes++;
      @(negedge clock);
   endtask

   task automatic offer_tick(tick_type t, bit known, motion_type known_motion);
      motion_type predicted;
      int      stay;
      stay = ($urandom_range(3) == 0 && tx_idle_pct != 0) ? 99 : tx_idle_pct;
      while ($urandom_range(99) < stay) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(t);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = smooth_tick(t);
      pending_motion.push_back(known ? known_motion : predicted);
      ticks_sent++;
      @(negedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_motion.size() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic random_tick();
      tick_type   t;
      motion_type none;
      if ($urandom_range(99) < 15) begin
         cur_x = $urandom_range(65535) - 32768;
         cur_y = $urandom_range(65535) - 32768;
      end else begin
         cur_x += $urandom_range(200) - 100;
         cur_y += $urandom_range(200) - 100;
      end
      t.px  = 16'(cur_x);
      t.py  = 16'(cur_y);
      cur_x = int'($signed(t.px));
      cur_y = int'($signed(t.py));
      if ($urandom_range(99) < 20) lvl_left = !lvl_left;
      if ($urandom_range(99) < 12) lvl_right = !lvl_right;
      t.left  = lvl_left;
      t.right = lvl_right;
      t.wheel = ($urandom_range(99) < 60) ? 16'($urandom_range(6) - 3) : 16'($urandom);
      none = '0;
      offer_tick(t, 1'b0, none);
   endtask

   initial begin : stimulus
      row_type    row;
      tick_type   t;
      motion_type typed;
      int      s;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_addr   = '0;
      csr_wdata  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int n = 0; n < TABLE_ROWS; n++) begin
         row = dir_rows[n];
         if (row.kind == ROW_CFG) begin
            settle();
            write_reg(row.addr, row.value);
         end else begin
            t.px                = 16'(row.px);
            t.py                = 16'(row.py);
            t.left              = row.left;
            t.right             = row.right;
            t.wheel             = 16'(row.wheel);
            typed.mx            = QUO_W'(row.kmx);
            typed.my            = QUO_W'(row.kmy);
            typed.left_press    = row.klp;
            typed.left_release  = row.klr;
            typed.right_press   = row.krp;
            typed.right_release = row.krr;
            typed.wheel         = 16'(row.wheel);
            offer_tick(t, row.kind == ROW_KNOWN, typed);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         settle();
         case (p % 5)
            0:       s = 32768;
            1:       s = 65535;
            2:       s = 0;
            3:       s = 1;
            default: s = $urandom_range(65535);
         endcase
         write_reg(CSR_SMOOTHING, s);
         write_reg(CSR_VISIBLE, $urandom_range(1));
         tx_idle_pct = (p == 4) ? 0 : 35;
         rx_idle_pct = tx_idle_pct;
         // stall the result side long enough for the block to back up its input
         if (p == 6) holds_asked++;
         repeat (PHASE_TICKS) random_tick();
      end

      settle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Covered %0d ticks (%0d in the directed table) over %0d register writes;",
               ticks_sent, 15, reg_writes);
      $display("%0d beats checked across both cursor modes, smoothing 0/1/max, saturation",
               beats_checked);
      $display("and a %0d-cycle output hold.", HOLD_CYCLES);
      if (mismatches == 0 && strays == 0 && pending_motion.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_asked != holds_served) begin
            holds_served++;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = rsp_tdata[$bits(motion_type)-1:0];
         if (pending_motion.size() == 0) begin
            strays++;
            if (strays + mismatches <= REPORT_MAX)
               $display("stray motion beat: mx %0d my %0d wheel %0d",
                        $signed(seen.mx), $signed(seen.my), $signed(seen.wheel));
         end else begin
            want = pending_motion.pop_front();
            beats_checked++;
            if (seen.mx !== want.mx || seen.my !== want.my ||
                seen.left_press !== want.left_press ||
                seen.left_release !== want.left_release ||
                seen.right_press !== want.right_press ||
                seen.right_release !== want.right_release ||
                seen.wheel !== want.wheel) begin
               mismatches++;
               if (strays + mismatches <= REPORT_MAX) begin
                  $display("beat %0d mismatch: expected mx %0d my %0d edges %b%b%b%b wheel %0d",
                           beats_checked, $signed(want.mx), $signed(want.my),
                           want.left_press, want.left_release, want.right_press,
                           want.right_release, $signed(want.wheel));
                  $display("               got      mx %0d my %0d edges %b%b%b%b wheel %0d",
                           $signed(seen.mx), $signed(seen.my), seen.left_press,
                           seen.left_release, seen.right_press, seen.right_release,
                           $signed(seen.wheel));
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d beats outstanding",
                  cycle_count, pending_motion.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

endmodule

// File: mouse_motion_smoother.f
src/mms_pkg.sv
src/mms_divider.sv
src/mouse_motion_smoother.sv
tb/tb_top.sv
